// ===== hw/rtl/wrsi_pkg.sv =====
// Shared types, codes and constants for the Wilder RSI / stochastic RSI core.
package wrsi_pkg;

    localparam int PRICE_W = 32;
    localparam int RSI_W   = 15;
    localparam int STO_W   = 17;
    localparam int FRAC    = 16;

    localparam logic [RSI_W-1:0] RSI_FULL = 15'd25600;

    localparam logic [1:0] OP_G = 2'd0;
    localparam logic [1:0] OP_L = 2'd1;
    localparam logic [1:0] OP_R = 2'd2;
    localparam logic [1:0] OP_S = 2'd3;

    typedef struct packed {
        logic       capture;
        logic       eval;
        logic       div_go;
        logic [1:0] op;
        logic       mul;
        logic       hist_wr;
        logic       scan_step;
        logic       out_load;
    } t_cmd;

    typedef struct packed {
        logic first;
        logic seed_more;
        logic div_done;
        logic lzero;
        logic stoch_more;
        logic scan_done;
        logic flat;
        logic out_free;
    } t_sts;

endpackage

// ===== hw/rtl/wrsi_in_if.sv =====
// Input request channel: closing price and restart flag.
interface wrsi_in_if;
    logic                        valid;
    logic                        ready;
    logic [wrsi_pkg::PRICE_W-1:0] price;
    logic                        restart;

    modport source (output valid, output price, output restart, input ready);
    modport sink   (input valid, input price, input restart, output ready);
endinterface

// ===== hw/rtl/wrsi_out_if.sv =====
// Output request channel: RSI and stochastic RSI result.
interface wrsi_out_if;
    logic                      valid;
    logic                      ready;
    logic                      rsi_valid;
    logic [wrsi_pkg::RSI_W-1:0] rsi;
    logic                      stoch_valid;
    logic [wrsi_pkg::STO_W-1:0] stoch_rsi;
    logic                      stoch_flat;

    modport source (output valid, output rsi_valid, output rsi, output stoch_valid,
                    output stoch_rsi, output stoch_flat, input ready);
    modport sink   (input valid, input rsi_valid, input rsi, input stoch_valid,
                    input stoch_rsi, input stoch_flat, output ready);
endinterface

// ===== hw/rtl/wrsi_ram.sv =====
// Generic simple dual-port RAM with registered read.
module wrsi_ram #(
    parameter int WIDTH = 15,
    parameter int DEPTH = 14
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== hw/rtl/wrsi_div.sv =====
// Dividers: restoring bit-serial divider and a byte-per-cycle divider by a constant.
module wrsi_div #(
    parameter int DVD_W = 64,
    parameter int DVS_W = 49
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DVS_W-1:0] i_divisor,
    output logic             o_done,
    output logic [DVD_W-1:0] o_quot
);
    localparam int CW = $clog2(DVD_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CW-1:0]    r_cnt;
    logic [DVD_W-1:0] r_q;
    logic [DVS_W-1:0] r_r;
    logic [DVS_W-1:0] r_d;
    logic [DVS_W:0]   rem_sh;
    logic [DVS_W:0]   diff;
    logic             ge;

    assign rem_sh = {r_r, r_q[DVD_W-1]};
    assign ge     = rem_sh >= {1'b0, r_d};
    assign diff   = rem_sh - {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(DVD_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q <= i_dividend;
            r_r <= '0;
            r_d <= i_divisor;
        end else if (r_busy) begin
            r_q <= {r_q[DVD_W-2:0], ge};
            r_r <= ge ? diff[DVS_W-1:0] : rem_sh[DVS_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
endmodule

// long division by a constant, one byte per cycle, digit by reciprocal multiply
module wrsi_cdiv #(
    parameter int DVD_W = 64,
    parameter int DIV   = 14
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    output logic             o_done,
    output logic [DVD_W-1:0] o_quot
);
    localparam int DG   = 8;
    localparam int ND   = (DVD_W + DG - 1) / DG;
    localparam int XW   = ND * DG;
    localparam int RB   = $clog2(DIV);
    localparam int VW   = RB + DG;
    localparam int SHR  = VW + RB;
    localparam int MULT = (2 ** SHR + DIV - 1) / DIV;
    localparam int MW   = SHR - RB + 2;
    localparam int PW   = VW + MW;
    localparam int CW   = $clog2(ND + 1);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [XW-1:0] r_x;
    logic [RB-1:0] r_rem;
    logic [VW-1:0] v;
    logic [PW-1:0] prod;
    logic [DG-1:0] qd;
    logic [RB-1:0] rn;

    assign v    = {r_rem, r_x[XW-1 -: DG]};
    assign prod = PW'(v) * PW'(MULT);
    assign qd   = DG'(prod >> SHR);
    assign rn   = RB'(v - VW'(qd) * VW'(DIV));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(ND);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x   <= XW'(i_dividend);
            r_rem <= '0;
        end else if (r_busy) begin
            r_x   <= {r_x[XW-DG-1:0], qd};
            r_rem <= rn;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_x[DVD_W-1:0];
endmodule

// ===== hw/rtl/wrsi_ctrl.sv =====
// Sequencer for the RSI datapath.
module wrsi_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  wrsi_pkg::t_sts i_sts,
    output logic           o_in_ready,
    output wrsi_pkg::t_cmd o_cmd
);
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_EVAL = 4'd1;
    localparam logic [3:0] S_G_GO = 4'd2;
    localparam logic [3:0] S_G_WT = 4'd3;
    localparam logic [3:0] S_L_GO = 4'd4;
    localparam logic [3:0] S_L_WT = 4'd5;
    localparam logic [3:0] S_MUL  = 4'd6;
    localparam logic [3:0] S_R_GO = 4'd7;
    localparam logic [3:0] S_R_WT = 4'd8;
    localparam logic [3:0] S_HWR  = 4'd9;
    localparam logic [3:0] S_SCAN = 4'd10;
    localparam logic [3:0] S_S_GO = 4'd11;
    localparam logic [3:0] S_S_WT = 4'd12;
    localparam logic [3:0] S_OUT  = 4'd13;

    logic [3:0] r_state;
    logic [3:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EVAL;
                end
            end
            S_EVAL: begin
                o_cmd.eval = 1'b1;
                n_state    = (i_sts.first || i_sts.seed_more) ? S_OUT : S_G_GO;
            end
            S_G_GO: begin
                o_cmd.div_go = 1'b1;
                o_cmd.op     = wrsi_pkg::OP_G;
                n_state      = S_G_WT;
            end
            S_G_WT: begin
                if (i_sts.div_done) begin
                    n_state = S_L_GO;
                end
            end
            S_L_GO: begin
                o_cmd.div_go = 1'b1;
                o_cmd.op     = wrsi_pkg::OP_L;
                n_state      = S_L_WT;
            end
            S_L_WT: begin
                if (i_sts.div_done) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_R_GO;
            end
            S_R_GO: begin
                o_cmd.div_go = 1'b1;
                o_cmd.op     = wrsi_pkg::OP_R;
                n_state      = i_sts.lzero ? S_HWR : S_R_WT;
            end
            S_R_WT: begin
                if (i_sts.div_done) begin
                    n_state = S_HWR;
                end
            end
            S_HWR: begin
                o_cmd.hist_wr = 1'b1;
                n_state       = i_sts.stoch_more ? S_OUT : S_SCAN;
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.scan_done) begin
                    n_state = S_S_GO;
                end
            end
            S_S_GO: begin
                o_cmd.div_go = 1'b1;
                o_cmd.op     = wrsi_pkg::OP_S;
                n_state      = i_sts.flat ? S_OUT : S_S_WT;
            end
            S_S_WT: begin
                if (i_sts.div_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end
endmodule

// ===== hw/rtl/wrsi_dp.sv =====
// Datapath: price state, Wilder averages, RSI history and output register.
module wrsi_dp #(
    parameter int RSI_PERIOD   = 14,
    parameter int STOCH_WINDOW = 14,
    parameter int PRICE_BITS   = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  wrsi_pkg::t_cmd               i_cmd,
    output wrsi_pkg::t_sts               o_sts,
    input  logic [wrsi_pkg::PRICE_W-1:0] i_price,
    input  logic                         i_restart,
    input  logic                         i_out_ready,
    output logic                         o_out_valid,
    output logic                         o_rsi_valid,
    output logic [wrsi_pkg::RSI_W-1:0]   o_rsi,
    output logic                         o_stoch_valid,
    output logic [wrsi_pkg::STO_W-1:0]   o_stoch_rsi,
    output logic                         o_stoch_flat
);
    localparam int PB     = PRICE_BITS;
    localparam int FR     = wrsi_pkg::FRAC;
    localparam int RW     = wrsi_pkg::RSI_W;
    localparam int SW     = wrsi_pkg::STO_W;
    localparam int AVG_W  = PB + FR;
    localparam int SH     = (PB > 32) ? PB - 32 : 0;
    localparam int RG_W   = AVG_W - SH;
    localparam int PROD_W = RG_W + RW;
    localparam int DVD_W  = (AVG_W + FR > PROD_W) ? AVG_W + FR : PROD_W;
    localparam int DVS_W  = RG_W + 1;
    localparam int SCW    = $clog2(RSI_PERIOD + 1);
    localparam int HAW    = $clog2(STOCH_WINDOW);
    localparam int HCW    = $clog2(STOCH_WINDOW + 1);

    logic [wrsi_pkg::PRICE_W-1:0] r_price;
    logic                         r_restart;
    logic [PB-1:0]                r_last;
    logic                         r_have;
    logic [SCW-1:0]               r_seed_cnt;
    logic                         r_mode_seed;
    logic [PB-1:0]                r_gain;
    logic [PB-1:0]                r_loss;
    logic [AVG_W-1:0]             r_avg_g;
    logic [AVG_W-1:0]             r_avg_l;
    logic [PROD_W-1:0]            r_prod;
    logic [1:0]                   r_op;
    logic                         r_up;
    logic [RW-1:0]                r_rsi;
    logic                         r_rsi_ok;
    logic                         r_st_ok;
    logic [SW-1:0]                r_sto;
    logic                         r_flat;
    logic [HAW-1:0]               r_hptr;
    logic [HCW-1:0]               r_hcnt;
    logic [HCW-1:0]               r_sidx;
    logic                         r_rd_v;
    logic                         r_sfirst;
    logic [RW-1:0]                r_lo;
    logic [RW-1:0]                r_hi;
    logic                         r_out_v;
    logic                         r_o_rsi_ok;
    logic [RW-1:0]                r_o_rsi;
    logic                         r_o_st_ok;
    logic [SW-1:0]                r_o_sto;
    logic                         r_o_flat;

    logic [PB-1:0]    pm;
    logic             first;
    logic             seed_act;
    logic [RG_W-1:0]  gs;
    logic [RG_W-1:0]  ls;
    logic             lzero;
    logic             flat;
    logic [AVG_W-1:0] sel_a;
    logic [AVG_W-1:0] sel_n;
    logic             up;
    logic [DVD_W-1:0] dvd;
    logic [DVS_W-1:0] dvs;
    logic             sdiv_start;
    logic             cdiv_start;
    logic             sdiv_done;
    logic             cdiv_done;
    logic [DVD_W-1:0] squot;
    logic [DVD_W-1:0] cquot;
    logic             div_done;
    logic [DVD_W-1:0] quot;
    logic [RW-1:0]    rdata;
    logic [RW-1:0]    rdiff;

    assign pm       = PB'(r_price);
    assign first    = r_restart || !r_have;
    assign seed_act = r_seed_cnt < SCW'(RSI_PERIOD);
    assign gs       = RG_W'(r_avg_g >> SH);
    assign ls       = RG_W'(r_avg_l >> SH);
    assign lzero    = (ls == '0);
    assign flat     = (r_hi == r_lo);
    assign rdiff    = r_rsi - r_lo;

    always_comb begin
        sel_a = (i_cmd.op == wrsi_pkg::OP_G) ? r_avg_g : r_avg_l;
        sel_n = (i_cmd.op == wrsi_pkg::OP_G) ? (AVG_W'(r_gain) << FR)
                                             : (AVG_W'(r_loss) << FR);
        up    = sel_n >= sel_a;
        dvd   = '0;
        dvs   = '0;
        unique case (i_cmd.op)
            wrsi_pkg::OP_G, wrsi_pkg::OP_L: begin
                if (r_mode_seed) begin
                    dvd = DVD_W'(sel_a) << FR;
                end else if (up) begin
                    dvd = DVD_W'(sel_n - sel_a);
                end else begin
                    dvd = DVD_W'(sel_a - sel_n) + DVD_W'(RSI_PERIOD - 1);
                end
            end
            wrsi_pkg::OP_R: begin
                dvd = DVD_W'(r_prod);
                dvs = DVS_W'(gs) + DVS_W'(ls);
            end
            wrsi_pkg::OP_S: begin
                dvd = DVD_W'(rdiff) << FR;
                dvs = DVS_W'(r_hi - r_lo);
            end
            default: begin
                dvd = '0;
            end
        endcase
    end

    assign cdiv_start = i_cmd.div_go
                        && (i_cmd.op == wrsi_pkg::OP_G || i_cmd.op == wrsi_pkg::OP_L);
    assign sdiv_start = i_cmd.div_go
                        && ((i_cmd.op == wrsi_pkg::OP_R && !lzero)
                            || (i_cmd.op == wrsi_pkg::OP_S && !flat));
    assign div_done   = sdiv_done || cdiv_done;
    assign quot       = (r_op == wrsi_pkg::OP_G || r_op == wrsi_pkg::OP_L) ? cquot : squot;

    wrsi_div #(.DVD_W(DVD_W), .DVS_W(DVS_W)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (sdiv_start),
        .i_dividend (dvd),
        .i_divisor  (dvs),
        .o_done     (sdiv_done),
        .o_quot     (squot)
    );

    wrsi_cdiv #(.DVD_W(DVD_W), .DIV(RSI_PERIOD)) u_cdiv (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (cdiv_start),
        .i_dividend (dvd),
        .o_done     (cdiv_done),
        .o_quot     (cquot)
    );

    wrsi_ram #(.WIDTH(RW), .DEPTH(STOCH_WINDOW)) u_hist (
        .i_clk   (i_clk),
        .i_we    (i_cmd.hist_wr),
        .i_waddr (r_hptr),
        .i_wdata (r_rsi),
        .i_raddr (r_sidx[HAW-1:0]),
        .o_rdata (rdata)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have     <= 1'b0;
            r_seed_cnt <= '0;
            r_hptr     <= '0;
            r_hcnt     <= '0;
            r_sidx     <= '0;
            r_rd_v     <= 1'b0;
            r_out_v    <= 1'b0;
            r_avg_g    <= '0;
            r_avg_l    <= '0;
            r_last     <= '0;
        end else begin
            if (i_cmd.eval) begin
                r_last <= pm;
                if (first) begin
                    r_have     <= 1'b1;
                    r_seed_cnt <= '0;
                    r_hptr     <= '0;
                    r_hcnt     <= '0;
                    r_avg_g    <= '0;
                    r_avg_l    <= '0;
                end else if (seed_act) begin
                    r_seed_cnt <= r_seed_cnt + 1'b1;
                    r_avg_g    <= r_avg_g + AVG_W'((pm > r_last) ? pm - r_last : '0);
                    r_avg_l    <= r_avg_l + AVG_W'((pm < r_last) ? r_last - pm : '0);
                end
            end
            if (div_done && (r_op == wrsi_pkg::OP_G)) begin
                if (r_mode_seed) begin
                    r_avg_g <= quot[AVG_W-1:0];
                end else begin
                    r_avg_g <= r_up ? r_avg_g + quot[AVG_W-1:0] : r_avg_g - quot[AVG_W-1:0];
                end
            end
            if (div_done && (r_op == wrsi_pkg::OP_L)) begin
                if (r_mode_seed) begin
                    r_avg_l <= quot[AVG_W-1:0];
                end else begin
                    r_avg_l <= r_up ? r_avg_l + quot[AVG_W-1:0] : r_avg_l - quot[AVG_W-1:0];
                end
            end
            if (i_cmd.hist_wr) begin
                r_hptr <= (r_hptr == HAW'(STOCH_WINDOW - 1)) ? '0 : r_hptr + 1'b1;
                if (r_hcnt < HCW'(STOCH_WINDOW)) begin
                    r_hcnt <= r_hcnt + 1'b1;
                end
                r_sidx <= '0;
                r_rd_v <= 1'b0;
            end else if (i_cmd.scan_step) begin
                r_rd_v <= r_sidx < HCW'(STOCH_WINDOW);
                if (r_sidx < HCW'(STOCH_WINDOW)) begin
                    r_sidx <= r_sidx + 1'b1;
                end
            end
            if (i_cmd.out_load) begin
                r_out_v <= 1'b1;
            end else if (i_out_ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_price   <= i_price;
            r_restart <= i_restart;
        end
        if (i_cmd.eval) begin
            r_gain      <= (pm > r_last) ? pm - r_last : '0;
            r_loss      <= (pm < r_last) ? r_last - pm : '0;
            r_mode_seed <= seed_act;
            r_rsi       <= '0;
            r_rsi_ok    <= 1'b0;
            r_st_ok     <= 1'b0;
            r_sto       <= '0;
            r_flat      <= 1'b0;
        end
        if (i_cmd.div_go) begin
            r_op <= i_cmd.op;
            r_up <= up;
        end
        if (i_cmd.mul) begin
            r_prod   <= PROD_W'(gs) * PROD_W'(wrsi_pkg::RSI_FULL);
            r_rsi_ok <= 1'b1;
        end
        if (i_cmd.div_go && (i_cmd.op == wrsi_pkg::OP_R) && lzero) begin
            r_rsi <= wrsi_pkg::RSI_FULL;
        end
        if (i_cmd.div_go && (i_cmd.op == wrsi_pkg::OP_S)) begin
            r_st_ok <= 1'b1;
            r_flat  <= flat;
        end
        if (div_done && (r_op == wrsi_pkg::OP_R)) begin
            r_rsi <= quot[RW-1:0];
        end
        if (div_done && (r_op == wrsi_pkg::OP_S)) begin
            r_sto <= quot[SW-1:0];
        end
        if (i_cmd.hist_wr) begin
            r_sfirst <= 1'b1;
        end else if (i_cmd.scan_step && r_rd_v) begin
            r_sfirst <= 1'b0;
            if (r_sfirst || rdata < r_lo) begin
                r_lo <= rdata;
            end
            if (r_sfirst || rdata > r_hi) begin
                r_hi <= rdata;
            end
        end
        if (i_cmd.out_load) begin
            r_o_rsi_ok <= r_rsi_ok;
            r_o_rsi    <= r_rsi;
            r_o_st_ok  <= r_st_ok;
            r_o_sto    <= r_sto;
            r_o_flat   <= r_flat;
        end
    end

    always_comb begin
        o_sts            = '0;
        o_sts.first      = first;
        o_sts.seed_more  = !first && (r_seed_cnt < SCW'(RSI_PERIOD - 1));
        o_sts.div_done   = div_done;
        o_sts.lzero      = lzero;
        o_sts.stoch_more = r_hcnt < HCW'(STOCH_WINDOW - 1);
        o_sts.scan_done  = r_rd_v && (r_sidx == HCW'(STOCH_WINDOW));
        o_sts.flat       = flat;
        o_sts.out_free   = !r_out_v || i_out_ready;
    end

    assign o_out_valid   = r_out_v;
    assign o_rsi_valid   = r_o_rsi_ok;
    assign o_rsi         = r_o_rsi;
    assign o_stoch_valid = r_o_st_ok;
    assign o_stoch_rsi   = r_o_sto;
    assign o_stoch_flat  = r_o_flat;
endmodule

// ===== hw/rtl/wilder_rsi_with_stochastic_rsi_core.sv =====
// Wilder RSI with stochastic RSI: one closing price in, one result out.
// Per price, the RSI and stochastic divisions take a bit per cycle and the two divisions
//   by RSI_PERIOD a byte per cycle; the RSI division is skipped when avg loss is zero, the
//   stochastic division when the window range is zero. Seed-phase prices before the last
//   skip all divisions. One price in flight; a new request is taken while the previous
//   result waits in the output register.
// Reset: synchronous active-low i_rst_n clears all history and the controller.
module wilder_rsi_with_stochastic_rsi_core #(
    parameter int RSI_PERIOD   = 14,
    parameter int STOCH_WINDOW = 14,
    parameter int PRICE_BITS   = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    wrsi_in_if.sink          i_in,
    wrsi_out_if.source       o_out
);
    wrsi_pkg::t_cmd cmd;
    wrsi_pkg::t_sts sts;

    wrsi_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_sts      (sts),
        .o_in_ready (i_in.ready),
        .o_cmd      (cmd)
    );

    wrsi_dp #(
        .RSI_PERIOD   (RSI_PERIOD),
        .STOCH_WINDOW (STOCH_WINDOW),
        .PRICE_BITS   (PRICE_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_price       (i_in.price),
        .i_restart     (i_in.restart),
        .i_out_ready   (o_out.ready),
        .o_out_valid   (o_out.valid),
        .o_rsi_valid   (o_out.rsi_valid),
        .o_rsi         (o_out.rsi),
        .o_stoch_valid (o_out.stoch_valid),
        .o_stoch_rsi   (o_out.stoch_rsi),
        .o_stoch_flat  (o_out.stoch_flat)
    );

    a_rsi_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.rsi_valid |-> o_out.rsi == '0 && !o_out.stoch_valid)
        else $error("rsi nonzero before seed complete");

    a_rsi_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> o_out.rsi <= wrsi_pkg::RSI_FULL && o_out.stoch_rsi <= 17'd65536)
        else $error("result out of range");

    a_flat_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.stoch_flat |-> o_out.stoch_valid && o_out.stoch_rsi == '0)
        else $error("flat window with nonzero stochastic rsi");

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.valid && i_in.ready |=> !i_in.ready)
        else $error("request accepted while busy");
endmodule

// ===== tb/wilder_rsi_with_stochastic_rsi_core_tb.sv =====
// Testbench for the Wilder RSI / stochastic RSI core: directed table plus random price series.
module wilder_rsi_with_stochastic_rsi_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PERIOD = 14;
    localparam int WINDOW = 14;
    localparam int N_RAND = 1080;

    typedef struct packed {
        logic                       rsi_valid;
        logic [wrsi_pkg::RSI_W-1:0] rsi;
        logic                       stoch_valid;
        logic [wrsi_pkg::STO_W-1:0] stoch_rsi;
        logic                       stoch_flat;
    } t_res;

    typedef struct {
        logic [wrsi_pkg::PRICE_W-1:0] price;
        logic                         restart;
        bit                           typed;
        t_res                         res;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    wrsi_in_if  in_ch ();
    wrsi_out_if out_ch ();

    wilder_rsi_with_stochastic_rsi_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // predictor state
    longint unsigned prev_price;
    bit              have_prev;
    int unsigned     seeded;
    longint unsigned gain_avg;
    longint unsigned loss_avg;
    int unsigned     rsi_ring[WINDOW];
    int unsigned     ring_ptr;
    int unsigned     ring_fill;

    t_res        expected_q[$];
    int unsigned errors = 0;
    int unsigned idle_pct = 0;
    int unsigned stall_pct = 0;

    task automatic report(string what, longint unsigned got, longint unsigned want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    function automatic void clear_history();
        prev_price = 0;
        have_prev = 0;
        seeded = 0;
        gain_avg = 0;
        loss_avg = 0;
        ring_ptr = 0;
        ring_fill = 0;
        foreach (rsi_ring[k]) rsi_ring[k] = 0;
    endfunction

    function automatic longint unsigned wilder(longint unsigned a, longint unsigned g);
        if (g >= a) return a + (g - a) / PERIOD;
        return a - ((a - g) + PERIOD - 1) / PERIOD;
    endfunction

    function automatic longint unsigned seed_avg(longint unsigned s);
        return ((s / PERIOD) << wrsi_pkg::FRAC) + (((s % PERIOD) << wrsi_pkg::FRAC) / PERIOD);
    endfunction

    function automatic t_res rsi_step(logic [wrsi_pkg::PRICE_W-1:0] price, logic restart);
        t_res r;
        longint unsigned p, g, l;
        int unsigned rsi, lo, hi;
        r = '0;
        p = price;
        if (restart) clear_history();
        if (!have_prev) begin
            prev_price = p;
            have_prev = 1;
            return r;
        end
        g = (p > prev_price) ? p - prev_price : 0;
        l = (p < prev_price) ? prev_price - p : 0;
        prev_price = p;
        if (seeded < PERIOD) begin
            gain_avg += g;
            loss_avg += l;
            seeded++;
            if (seeded < PERIOD) return r;
            gain_avg = seed_avg(gain_avg);
            loss_avg = seed_avg(loss_avg);
        end else begin
            gain_avg = wilder(gain_avg, g << wrsi_pkg::FRAC);
            loss_avg = wilder(loss_avg, l << wrsi_pkg::FRAC);
        end
        if (loss_avg == 0) rsi = 25600;
        else rsi = int'((64'd25600 * gain_avg) / (gain_avg + loss_avg));
        r.rsi_valid = 1'b1;
        r.rsi = rsi[wrsi_pkg::RSI_W-1:0];
        rsi_ring[ring_ptr] = rsi;
        ring_ptr = (ring_ptr + 1 >= WINDOW) ? 0 : ring_ptr + 1;
        if (ring_fill < WINDOW) ring_fill++;
        if (ring_fill < WINDOW) return r;
        lo = rsi_ring[0];
        hi = rsi_ring[0];
        foreach (rsi_ring[k]) begin
            if (rsi_ring[k] < lo) lo = rsi_ring[k];
            if (rsi_ring[k] > hi) hi = rsi_ring[k];
        end
        r.stoch_valid = 1'b1;
        if (hi == lo) r.stoch_flat = 1'b1;
        else r.stoch_rsi = wrsi_pkg::STO_W'((longint'(rsi - lo) * 65536) / (hi - lo));
        return r;
    endfunction

    task automatic send_price(logic [wrsi_pkg::PRICE_W-1:0] price, logic restart, bit typed,
                              t_res want);
        t_res pred;
        while (idle_pct != 0 && $urandom_range(99, 0) < idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.price   <= price;
        in_ch.restart <= restart;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        pred = rsi_step(price, restart);
        expected_q.insert(expected_q.size(), typed ? want : pred);
    endtask

    // result checker and receiver stalls
    always @(posedge i_clk) begin
        t_res want;
        if (out_ch.valid && out_ch.ready) begin
            if (expected_q.size() == 0) begin
                report("unexpected result", 1, 0);
            end else begin
                want = expected_q.pop_front();
                if (out_ch.rsi_valid !== want.rsi_valid)
                    report("rsi_valid", out_ch.rsi_valid, want.rsi_valid);
                if (out_ch.rsi !== want.rsi) report("rsi", out_ch.rsi, want.rsi);
                if (out_ch.stoch_valid !== want.stoch_valid)
                    report("stoch_valid", out_ch.stoch_valid, want.stoch_valid);
                if (out_ch.stoch_rsi !== want.stoch_rsi)
                    report("stoch_rsi", out_ch.stoch_rsi, want.stoch_rsi);
                if (out_ch.stoch_flat !== want.stoch_flat)
                    report("stoch_flat", out_ch.stoch_flat, want.stoch_flat);
            end
        end
        out_ch.ready <= !(stall_pct != 0 && $urandom_range(99, 0) < stall_pct);
    end

    initial begin
        t_row rows[$];
        t_row row;
        t_res full;
        logic [wrsi_pkg::PRICE_W-1:0] base, step;
        int unsigned len, mode, n;

        in_ch.valid = 1'b0;
        in_ch.price = '0;
        in_ch.restart = 1'b0;
        out_ch.ready = 1'b0;
        clear_history();

        // directed: first price, flat seed, extremes, restart
        full = '0;
        full.rsi_valid = 1'b1;
        full.rsi = wrsi_pkg::RSI_FULL;
        for (int k = 0; k < 15; k++) begin
            row.price = 32'd100 << 16;
            row.restart = 1'b0;
            row.typed = 1'b1;
            row.res = (k == 14) ? full : '0;
            rows.insert(rows.size(), row);
        end
        row.typed = 1'b0;
        row.res = '0;
        row.restart = 1'b0;
        row.price = 32'hFFFF_FFFF; rows.insert(rows.size(), row);
        row.price = 32'h0;         rows.insert(rows.size(), row);
        row.price = 32'hFFFF_FFFF; rows.insert(rows.size(), row);
        row.price = 32'h0000_0001; rows.insert(rows.size(), row);
        row.price = 32'd5; row.restart = 1'b1; row.typed = 1'b1; rows.insert(rows.size(), row);
        row.restart = 1'b0; row.typed = 1'b0;
        row.price = 32'hAAAA_5555; rows.insert(rows.size(), row);
        row.price = 32'h5555_AAAA; rows.insert(rows.size(), row);
        row.price = 32'h8000_0000; rows.insert(rows.size(), row);

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[k]) send_price(rows[k].price, rows[k].restart, rows[k].typed, rows[k].res);

        // random series: mostly well-formed runs long enough to fill both windows
        n = 0;
        while (n < N_RAND) begin
            case ((n * 4) / N_RAND)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 50; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 50; end
                default: begin idle_pct = 32; stall_pct = 32; end
            endcase
            len = $urandom_range(60, 20);
            mode = $urandom_range(5, 0);
            base = $urandom();
            step = $urandom_range(4096, 1);
            for (int k = 0; k < len && n < N_RAND; k++) begin
                case (mode)
                    0: base = $urandom();
                    1: base = base + $urandom_range(512, 0) - 256;
                    2: ;
                    3: base = base + step;
                    4: base = base - step;
                    default: base = ($urandom_range(9, 0) == 0) ? $urandom()
                                    : base + $urandom_range(65535, 0) - 32768;
                endcase
                send_price(base, (k == 0) || ($urandom_range(99, 0) == 0), 1'b0, '0);
                n++;
            end
        end
        in_ch.valid <= 1'b0;

        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
        if (errors == 0)
            $display("wilder_rsi_with_stochastic_rsi_core_tb passed");
        else
            $display("wilder_rsi_with_stochastic_rsi_core_tb failed");
        $finish;
    end

    initial begin
        #200ms;
        $display("wilder_rsi_with_stochastic_rsi_core_tb failed");
        $finish;
    end
endmodule
